@@ design/spn_pkg.sv @@
`default_nettype none

package spn_pkg;

    localparam int unsigned BlockW  = 16;
    localparam int unsigned NibbleW = 4;
    localparam int unsigned Nibbles = BlockW / NibbleW;

    typedef logic [BlockW-1:0] t_block;
    typedef logic [NibbleW-1:0] t_nibble;

    typedef enum logic [1:0] {
        STAGE_WHITEN,
        STAGE_FULL,
        STAGE_LAST
    } t_stage_kind;

    localparam t_nibble SBOX [16] = '{
        4'h5, 4'h6, 4'h2, 4'h0,
        4'h7, 4'hB, 4'h3, 4'hF,
        4'hC, 4'h1, 4'h4, 4'h8,
        4'h9, 4'hD, 4'hA, 4'hE
    };

    function automatic t_block sub_nibbles(input t_block v);
        t_block r;
        r = '0;
        for (int n = 0; n < Nibbles; n++) begin
            r[n*NibbleW +: NibbleW] = SBOX[v[n*NibbleW +: NibbleW]];
        end
        return r;
    endfunction

    // bit 4r+c moves to bit 4c+r
    function automatic t_block transpose4x4(input t_block v);
        t_block r;
        r = '0;
        for (int row = 0; row < Nibbles; row++) begin
            for (int col = 0; col < Nibbles; col++) begin
                r[col*NibbleW + row] = v[row*NibbleW + col];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/spn_if.sv @@
`default_nettype none

interface spn_pt_if;
    import spn_pkg::*;

    logic   valid;
    logic   ready;
    t_block plaintext;

    modport source (output valid, output plaintext, input ready);
    modport sink   (input valid, input plaintext, output ready);
endinterface

interface spn_ct_if;
    import spn_pkg::*;

    logic   valid;
    logic   ready;
    t_block ciphertext;

    modport source (output valid, output ciphertext, input ready);
    modport sink   (input valid, input ciphertext, output ready);
endinterface

`default_nettype wire

@@ design/spn_stage.sv @@
`default_nettype none

module spn_stage
    import spn_pkg::*;
#(
    parameter t_stage_kind KIND = STAGE_FULL
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_block i_key,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_block i_data,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_block      o_data
);

    logic   r_vld;
    t_block r_data;
    t_block n_data;

    always_comb begin
        case (KIND)
            STAGE_WHITEN: n_data = i_data ^ i_key;
            STAGE_FULL:   n_data = transpose4x4(sub_nibbles(i_data)) ^ i_key;
            STAGE_LAST:   n_data = sub_nibbles(i_data) ^ i_key;
            default:      n_data = i_data ^ i_key;
        endcase
    end

    // take a new transaction when empty or when the held one moves on
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ design/spn16_block_encrypt.sv @@
`default_nettype none
// Channel   Dir  Payload            Handshake
// i_pt      in   plaintext[15:0]    valid/ready
// o_ct      out  ciphertext[15:0]   valid/ready
// cfg       in   i_cfg_wdata[15:0]  i_cfg_we (round_key)
//
// One transaction per cycle while o_ct is ready, through ROUNDS+1 register stages,
// one per round plus the key whitening stage; the ciphertext is driven at o_ct
// from the register of the last stage. Every stage has its own valid bit and
// ready chains back stage by stage, so bubbles are squeezed out and input is
// taken while a result waits at o_ct as long as some stage is empty.
// Reset (synchronous, active low) empties the pipeline and clears round_key.

module spn16_block_encrypt
    import spn_pkg::*;
#(
    parameter int unsigned ROUNDS = 7
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire t_block i_cfg_wdata,
    spn_pt_if.sink      i_pt,
    spn_ct_if.source    o_ct
);

    localparam int unsigned Stages = ROUNDS + 1;

    t_block r_round_key;

    logic   [Stages:0] w_vld;
    logic   [Stages:0] w_rdy;
    t_block            w_data [Stages+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_key <= '0;
        end else if (i_cfg_we) begin
            r_round_key <= i_cfg_wdata;
        end
    end

    assign w_vld[0]  = i_pt.valid;
    assign w_data[0] = i_pt.plaintext;
    assign i_pt.ready = w_rdy[0];

    for (genvar s = 0; s < Stages; s++) begin : g_stage
        localparam t_stage_kind Kind = (s == 0) ? STAGE_WHITEN :
                                       (s == Stages - 1) ? STAGE_LAST : STAGE_FULL;
        spn_stage #(
            .KIND (Kind)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_round_key),
            .i_valid (w_vld[s]),
            .o_ready (w_rdy[s]),
            .i_data  (w_data[s]),
            .o_valid (w_vld[s+1]),
            .i_ready (w_rdy[s+1]),
            .o_data  (w_data[s+1])
        );
    end

    assign w_rdy[Stages]  = o_ct.ready;
    assign o_ct.valid      = w_vld[Stages];
    assign o_ct.ciphertext = w_data[Stages];

    // input stalls only when every stage holds a transaction
    a_full_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> (&w_vld[Stages:1]))
        else $error("input stalled with a bubble in the pipeline");

    a_ready_reaches_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ct.ready |-> i_pt.ready)
        else $error("output ready did not propagate to input");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> w_vld[1])
        else $error("accepted transaction not held in first stage");

    a_stalled_result_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[Stages] && !o_ct.ready) |=> (w_vld[Stages] && $stable(w_data[Stages])))
        else $error("waiting result lost or changed");

endmodule

`default_nettype wire
